// ----- rtl/vrsu_pkg.sv -----
// Shared types and constants for the video register and scroll unit.
// No dependencies; imported by vrsu_timing, vrsu_scroll, the top level and the testbench.
`default_nettype none

package vrsu_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // CPU-visible register numbers
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_idx_t;

  // Frame geometry
  localparam int OAM_BYTES       = 256;
  localparam int OAM_AW          = 8;
  localparam logic [8:0] DOTS_PER_LINE = 9'd341;
  localparam logic signed [9:0] LINE_WRAP     = 10'sd261;  // LINES_PER_FRAME - 1
  localparam logic signed [9:0] LINE_PRE      = -10'sd1;
  localparam logic signed [9:0] LINE_FIRST    = 10'sd0;
  localparam logic signed [9:0] LINE_LAST_VIS = 10'sd239;
  localparam logic signed [9:0] LINE_VBL      = 10'sd241;

  // Dot positions of the scroll and flag events
  localparam logic [8:0] DOT_FLAG      = 9'd1;
  localparam logic [8:0] DOT_Y_INC     = 9'd256;
  localparam logic [8:0] DOT_X_COPY    = 9'd257;
  localparam logic [8:0] DOT_Y_COPY_LO = 9'd280;
  localparam logic [8:0] DOT_Y_COPY_HI = 9'd304;
  localparam logic [8:0] DOT_SPR_HI    = 9'd320;
  localparam logic [8:0] DOT_PREFETCH  = 9'd328;

  // Address fields
  localparam logic [4:0] COARSE_Y_WRAP = 5'd29;
  localparam logic [4:0] COARSE_MAX    = 5'd31;
  localparam logic [5:0] PALETTE_PAGE  = 6'h3F;

  // Timing view handed from the counters to the rest of the block
  typedef struct packed {
    logic [8:0]        dot;
    logic signed [9:0] line;
    logic              pre_clear;    // prerender line, dot 1
    logic              vbl_start;    // line 241, dot 1
    logic              render_line;  // prerender or visible line
    logic              sprite_clear; // sprite fetch window, attribute index reset
    logic              frame_done;   // this tick wraps to prerender
    logic [8:0]        dot_after;
    logic signed [9:0] line_after;
  } vrsu_timing_t;

endpackage

`default_nettype wire

// ----- rtl/vrsu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vrsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/vrsu_timing.sv -----
// Dot and line counters with odd-frame skip, and the event decodes they drive.
// Depends on vrsu_pkg.
`default_nettype none

module vrsu_timing
  import vrsu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   tick,
  output vrsu_timing_t tm
);

  logic [8:0]        dot;
  logic signed [9:0] line;
  logic              frame_parity;
  logic [8:0]        dot_next;
  logic signed [9:0] line_next;
  logic              frame_parity_next;
  logic [8:0]        dot_inc;
  logic [8:0]        dot_wrap;
  logic signed [9:0] line_wrap;
  logic              wrap_frame;
  logic              line0_start;

  // counter advance for one tick
  always_comb begin
    dot_inc    = dot + 9'd1;
    dot_wrap   = dot_inc;
    line_wrap  = line;
    wrap_frame = 1'b0;
    if (dot_inc >= DOTS_PER_LINE) begin
      dot_wrap  = '0;
      line_wrap = line + 10'sd1;
      if (line_wrap >= LINE_WRAP) begin
        line_wrap  = LINE_PRE;
        wrap_frame = 1'b1;
      end
    end
    line0_start = (line_wrap == LINE_FIRST) && (dot_wrap == '0);
  end

  always_comb begin
    dot_next          = dot;
    line_next         = line;
    frame_parity_next = frame_parity;
    if (tick) begin
      dot_next          = (line0_start && frame_parity) ? 9'd1 : dot_wrap;
      line_next         = line_wrap;
      frame_parity_next = frame_parity ^ line0_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot          <= '0;
      line         <= LINE_PRE;
      frame_parity <= 1'b0;
    end else begin
      dot          <= dot_next;
      line         <= line_next;
      frame_parity <= frame_parity_next;
    end
  end

  // decodes on the current position
  always_comb begin
    tm.dot          = dot;
    tm.line         = line;
    tm.pre_clear    = (line == LINE_PRE) && (dot == DOT_FLAG);
    tm.vbl_start    = (line == LINE_VBL) && (dot == DOT_FLAG);
    tm.render_line  = (line <= LINE_LAST_VIS);
    tm.sprite_clear = (line <= LINE_LAST_VIS) && (dot >= DOT_X_COPY) && (dot <= DOT_SPR_HI);
    tm.frame_done   = wrap_frame;
    tm.dot_after    = dot_next;
    tm.line_after   = line_next;
  end

endmodule

`default_nettype wire

// ----- rtl/vrsu_scroll.sv -----
// Scroll increments and copies applied to the current video address on a tick.
// Depends on vrsu_pkg.
`default_nettype none

module vrsu_scroll
  import vrsu_pkg::*;
(
  input  wire logic         enable,
  input  wire vrsu_timing_t tm,
  input  wire logic [14:0]  cur_addr,
  input  wire logic [14:0]  tmp_addr,
  output logic      [14:0]  cur_addr_next
);

  logic [14:0] v;
  logic [4:0]  cy;

  always_comb begin
    v  = cur_addr;
    cy = cur_addr[9:5];
    if (enable) begin
      // vertical increment, horizontal copy, vertical copy on prerender
      if (tm.dot == DOT_Y_INC) begin
        if (v[14:12] != 3'd7) begin
          v[14:12] = v[14:12] + 3'd1;
        end else begin
          v[14:12] = 3'd0;
          if (cy == COARSE_Y_WRAP) begin
            cy    = '0;
            v[11] = ~v[11];
          end else if (cy == COARSE_MAX) begin
            cy = '0;
          end else begin
            cy = cy + 5'd1;
          end
          v[9:5] = cy;
        end
      end else if (tm.dot == DOT_X_COPY) begin
        v[10]  = tmp_addr[10];
        v[4:0] = tmp_addr[4:0];
      end else if (tm.dot >= DOT_Y_COPY_LO && tm.dot <= DOT_Y_COPY_HI &&
                   tm.line == LINE_PRE) begin
        v[14:11] = tmp_addr[14:11];
        v[9:5]   = tmp_addr[9:5];
      end

      // coarse X step every eight dots of the fetch windows
      if ((tm.dot >= DOT_PREFETCH || tm.dot <= DOT_Y_INC) && tm.dot != '0 &&
          tm.dot[2:0] == 3'd0) begin
        if (v[4:0] == COARSE_MAX) begin
          v[4:0] = '0;
          v[10]  = ~v[10];
        end else begin
          v[4:0] = v[4:0] + 5'd1;
        end
      end
    end
    cur_addr_next = v;
  end

endmodule

`default_nettype wire

// ----- rtl/video_register_scroll_unit.sv -----
// Top level of the video register and scroll unit: input register, register
// file, address logic and result register. Depends on vrsu_pkg, vrsu_ram,
// vrsu_timing and vrsu_scroll.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  input   | in_valid / in_ready | op, reg_index, write_data, mem_read_data,
//          |                     | overflow_event, zero_hit_event
//  result  | out_valid/out_ready | read_data, mem_addr, mem_write,
//          |                     | mem_write_data, mem_read, video_address,
//          |                     | fine_x_scroll, nmi_pulse, frame_done, dot, line
//
// One beat per cycle sustained while out_ready stays high; a beat's result is
// registered first in the input register, then in the result register.
// Every item is worked by the logic between the two registers; the
// attribute store read comes from the RAM's registered port, addressed with
// the index the previous item leaves.
// While the result register is held by out_ready low, the input register holds
// one more beat and in_ready drops. Reset (synchronous) empties both registers.
`default_nettype none

module video_register_scroll_unit
  import vrsu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        op,
  input  wire logic [2:0]        reg_index,
  input  wire logic [7:0]        write_data,
  input  wire logic [7:0]        mem_read_data,
  input  wire logic              overflow_event,
  input  wire logic              zero_hit_event,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        read_data,
  output logic      [13:0]       mem_addr,
  output logic                   mem_write,
  output logic      [7:0]        mem_write_data,
  output logic                   mem_read,
  output logic      [14:0]       video_address,
  output logic      [2:0]        fine_x_scroll,
  output logic                   nmi_pulse,
  output logic                   frame_done,
  output logic      [8:0]        dot,
  output logic signed [9:0]      line
);

  // input register
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [2:0] s1_reg;
  logic [7:0] s1_wdata;
  logic [7:0] s1_mdat;
  logic       s1_ovf;
  logic       s1_zhit;
  logic       adv;
  logic       tick;

  // architectural state
  logic [14:0]       cur_addr, cur_addr_next;
  logic [14:0]       tmp_addr, tmp_addr_next;
  logic [2:0]        fine_x, fine_x_next;
  logic              first_write, first_write_next;
  logic [7:0]        ctrl, ctrl_next;
  logic [7:0]        mask, mask_next;
  logic [2:0]        status, status_next;
  logic [7:0]        read_buffer, read_buffer_next;
  logic [OAM_AW-1:0] oam_index, oam_index_next;

  logic [14:0]  scroll_addr;
  logic [14:0]  addr_step;
  logic [7:0]   oam_rdata;
  logic         oam_we;
  vrsu_timing_t tm;

  // result fields before the result register
  logic [7:0]  r_rdata;
  logic [13:0] r_maddr;
  logic        r_mwr;
  logic [7:0]  r_mwdata;
  logic        r_mrd;
  logic        r_nmi;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;
  assign tick     = adv && (op_t'(s1_op) == OP_TICK);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op    <= op;
      s1_reg   <= reg_index;
      s1_wdata <= write_data;
      s1_mdat  <= mem_read_data;
      s1_ovf   <= overflow_event;
      s1_zhit  <= zero_hit_event;
    end
  end

  vrsu_timing u_timing (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .tm   (tm)
  );

  vrsu_scroll u_scroll (
    .enable        ((mask[4:3] != 2'b00) && tm.render_line),
    .tm            (tm),
    .cur_addr      (cur_addr),
    .tmp_addr      (tmp_addr),
    .cur_addr_next (scroll_addr)
  );

  // sprite attribute store, read address follows the index after each beat
  vrsu_ram #(
    .WIDTH (8),
    .DEPTH (OAM_BYTES)
  ) u_oam (
    .clk   (clk),
    .we    (oam_we),
    .waddr (oam_index),
    .wdata (s1_wdata),
    .raddr (oam_index_next),
    .rdata (oam_rdata)
  );

  assign addr_step = ctrl[2] ? 15'd32 : 15'd1;

  // per-item register and address logic
  always_comb begin
    cur_addr_next    = cur_addr;
    tmp_addr_next    = tmp_addr;
    fine_x_next      = fine_x;
    first_write_next = first_write;
    ctrl_next        = ctrl;
    mask_next        = mask;
    status_next      = status;
    read_buffer_next = read_buffer;
    oam_index_next   = oam_index;
    oam_we           = 1'b0;
    r_rdata          = '0;
    r_maddr          = '0;
    r_mwr            = 1'b0;
    r_mwdata         = '0;
    r_mrd            = 1'b0;
    r_nmi            = 1'b0;
    if (adv) begin
      case (op_t'(s1_op))
        OP_TICK: begin
          status_next    = tm.pre_clear ? 3'b000 : status;
          status_next[0] = status_next[0] | s1_ovf;
          status_next[1] = status_next[1] | s1_zhit;
          cur_addr_next  = scroll_addr;
          if (tm.vbl_start) begin
            status_next[2] = 1'b1;
            r_nmi          = ctrl[7];
          end
          if (tm.sprite_clear) begin
            oam_index_next = '0;
          end
        end
        OP_WRITE: begin
          case (reg_idx_t'(s1_reg))
            REG_CTRL: begin
              ctrl_next            = s1_wdata;
              tmp_addr_next[11:10] = s1_wdata[1:0];
            end
            REG_MASK: mask_next = s1_wdata;
            REG_OAM_ADDR: oam_index_next = s1_wdata[OAM_AW-1:0];
            REG_OAM_DATA: begin
              oam_we         = 1'b1;
              oam_index_next = oam_index + OAM_AW'(1);
            end
            REG_SCROLL: begin
              if (first_write) begin
                tmp_addr_next[4:0] = s1_wdata[7:3];
                fine_x_next        = s1_wdata[2:0];
              end else begin
                tmp_addr_next[9:5]   = s1_wdata[7:3];
                tmp_addr_next[14:12] = s1_wdata[2:0];
              end
              first_write_next = ~first_write;
            end
            REG_ADDR: begin
              if (first_write) begin
                tmp_addr_next[14]   = 1'b0;
                tmp_addr_next[13:8] = s1_wdata[5:0];
              end else begin
                tmp_addr_next[7:0] = s1_wdata;
                cur_addr_next      = {tmp_addr[14:8], s1_wdata};
              end
              first_write_next = ~first_write;
            end
            REG_DATA: begin
              r_maddr       = cur_addr[13:0];
              r_mwr         = 1'b1;
              r_mwdata      = s1_wdata;
              cur_addr_next = cur_addr + addr_step;
            end
            default: ;
          endcase
        end
        OP_READ: begin
          case (reg_idx_t'(s1_reg))
            REG_STATUS: begin
              r_rdata          = {status, read_buffer[4:0]};
              status_next[2]   = 1'b0;
              first_write_next = 1'b1;
            end
            REG_OAM_DATA: r_rdata = oam_rdata;
            REG_DATA: begin
              r_maddr          = cur_addr[13:0];
              r_mrd            = 1'b1;
              // palette reads bypass the buffer
              r_rdata          = (cur_addr[13:8] == PALETTE_PAGE) ? s1_mdat : read_buffer;
              read_buffer_next = s1_mdat;
              cur_addr_next    = cur_addr + addr_step;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr    <= '0;
      tmp_addr    <= '0;
      fine_x      <= '0;
      first_write <= 1'b1;
      ctrl        <= '0;
      mask        <= '0;
      status      <= '0;
      read_buffer <= '0;
      oam_index   <= '0;
    end else begin
      cur_addr    <= cur_addr_next;
      tmp_addr    <= tmp_addr_next;
      fine_x      <= fine_x_next;
      first_write <= first_write_next;
      ctrl        <= ctrl_next;
      mask        <= mask_next;
      status      <= status_next;
      read_buffer <= read_buffer_next;
      oam_index   <= oam_index_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_data      <= r_rdata;
      mem_addr       <= r_maddr;
      mem_write      <= r_mwr;
      mem_write_data <= r_mwdata;
      mem_read       <= r_mrd;
      video_address  <= cur_addr_next;
      fine_x_scroll  <= fine_x_next;
      nmi_pulse      <= r_nmi;
      frame_done     <= tick && tm.frame_done;
      dot            <= tm.dot_after;
      line           <= tm.line_after;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/vrsu_checker.sv -----
// Port-level checks for the video register and scroll unit, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module vrsu_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              mem_write,
  input wire logic              mem_read,
  input wire logic              nmi_pulse,
  input wire logic              frame_done,
  input wire logic       [7:0]  read_data,
  input wire logic       [8:0]  dot,
  input wire logic signed [9:0] line
);

  // a held result beat keeps its read data and dot
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(dot))
    else $error("result beat changed while stalled");

  // a beat is never both a memory write and a memory read
  a_mem_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mem_write && mem_read))
    else $error("data port write and read in one beat");

  // frame wrap lands on the prerender line, dot 0
  a_frame_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> (line == -10'sd1) && (dot == 9'd0))
    else $error("frame_done away from prerender start");

  // NMI only as the counters leave line 241, dot 1
  a_nmi_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && nmi_pulse |-> (line == 10'sd241) && (dot == 9'd2))
    else $error("nmi_pulse away from vertical blank start");

  // counters stay inside the frame
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dot <= 9'd340) && (line >= -10'sd1) && (line <= 10'sd260))
    else $error("dot or line out of range");

endmodule

bind video_register_scroll_unit vrsu_checker u_vrsu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .mem_write  (mem_write),
  .mem_read   (mem_read),
  .nmi_pulse  (nmi_pulse),
  .frame_done (frame_done),
  .read_data  (read_data),
  .dot        (dot),
  .line       (line)
);

`default_nettype wire

// ----- test/video_register_scroll_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for video_register_scroll_unit: directed register table, then
// random CPU register traffic between short dot-tick runs. Needs vrsu_pkg and the block's RTL.

module video_register_scroll_unit_tb;
  import vrsu_pkg::*;

  // op value with no meaning to the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT      = 21;
  localparam int LONG_HOLD     = 300;
  localparam int ITEM_TARGET   = 500;

  // One input beat; pinned rows carry a read byte typed in by hand
  typedef struct packed {
    logic [1:0] op;
    reg_idx_t   reg_sel;
    logic [7:0] wdata;
    logic [7:0] mdata;
    logic       ovf;
    logic       zhit;
    logic       pinned;
    logic [7:0] pin_rd;
  } beat_t;

  // One result beat as the block presents it
  typedef struct packed {
    logic [7:0]  read_data;
    logic [13:0] mem_addr;
    logic        mem_write;
    logic [7:0]  mem_write_data;
    logic        mem_read;
    logic [14:0] video_address;
    logic [2:0]  fine_x;
    logic        nmi;
    logic        frame_done;
    logic [8:0]  dot;
    logic [9:0]  line;
  } reply_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        op;
  logic [2:0]        reg_index;
  logic [7:0]        write_data;
  logic [7:0]        mem_read_data;
  logic              overflow_event;
  logic              zero_hit_event;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        read_data;
  logic [13:0]       mem_addr;
  logic              mem_write;
  logic [7:0]        mem_write_data;
  logic              mem_read;
  logic [14:0]       video_address;
  logic [2:0]        fine_x_scroll;
  logic              nmi_pulse;
  logic              frame_done;
  logic [8:0]        dot;
  logic signed [9:0] line;

  // Side band travelling with the payload, and process controls
  logic       pin_on;
  logic [7:0] pin_rd;
  logic       gaps_on;
  int         holds_asked;

  reply_t unit_replies[$];
  int     bad_fields    = 0;
  int     ticks_sent    = 0;
  int     accesses_sent = 0;

  // Local copy of the unit's state, at reset values
  logic [14:0] v_addr  = '0;
  logic [14:0] t_addr  = '0;
  logic [2:0]  fx      = '0;
  logic        w_first = 1'b1;
  logic [7:0]  ctrl_r  = '0;
  logic [7:0]  mask_r  = '0;
  logic [2:0]  flags   = '0;  // bit 0 overflow, bit 1 zero hit, bit 2 vblank
  logic [7:0]  rbuf    = '0;
  logic [7:0]  oam_ptr = '0;
  logic [7:0]  oam_mem [OAM_BYTES];
  int          dot_n   = 0;
  int          line_n  = -1;
  logic        odd_n   = 1'b0;

  // Directed rows: extremes, every register written, five of them read, the odd cases
  localparam beat_t DIR_ROWS [25] = '{
    '{OP_READ,   REG_STATUS,   8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00}, // status after reset
    '{OP_WRITE,  REG_CTRL,     8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00}, // nmi on, step 32
    '{OP_WRITE,  REG_MASK,     8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  REG_OAM_ADDR, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  REG_OAM_DATA, 8'hA5, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00}, // top entry, index wraps
    '{OP_WRITE,  REG_OAM_ADDR, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_READ,   REG_OAM_DATA, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 8'hA5},
    '{OP_WRITE,  REG_SCROLL,   8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  REG_SCROLL,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_READ,   REG_CTRL,     8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00}, // write-only register
    '{OP_WRITE,  REG_ADDR,     8'h3F, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  REG_ADDR,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_READ,   REG_DATA,     8'h00, 8'h5A, 1'b0, 1'b0, 1'b1, 8'h5A}, // palette bypass
    '{OP_WRITE,  REG_DATA,     8'hC3, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  REG_CTRL,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  REG_ADDR,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  REG_ADDR,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_READ,   REG_DATA,     8'h00, 8'h11, 1'b0, 1'b0, 1'b1, 8'h5A}, // buffered read
    '{OP_READ,   REG_DATA,     8'h00, 8'h22, 1'b0, 1'b0, 1'b1, 8'h11},
    '{OP_UNUSED, REG_DATA,     8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00}, // spare op
    '{OP_WRITE,  REG_STATUS,   8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00}, // ignored write
    '{OP_TICK,   REG_CTRL,     8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00}, // both sprite flags
    '{OP_READ,   REG_STATUS,   8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_READ,   REG_SCROLL,   8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00},
    '{OP_WRITE,  REG_MASK,     8'h18, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00}
  };

  video_register_scroll_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("FAILURE");
    $finish;
  end

  // Scroll increments and copies of one dot while rendering
  function automatic void scroll_step();
    logic [14:0] v;
    logic [4:0]  cy;
    if (mask_r[4:3] == 2'b00 || line_n > 239) return;
    v = v_addr;
    if (dot_n == 256) begin
      if (v[14:12] != 3'd7) begin
        v[14:12] = v[14:12] + 3'd1;
      end else begin
        v[14:12] = 3'd0;
        cy = v[9:5];
        if (cy == COARSE_Y_WRAP) begin
          cy = 5'd0;
          v[11] = ~v[11];
        end else if (cy == COARSE_MAX) begin
          cy = 5'd0;
        end else begin
          cy = cy + 5'd1;
        end
        v[9:5] = cy;
      end
    end else if (dot_n == 257) begin
      v[10]  = t_addr[10];
      v[4:0] = t_addr[4:0];
    end else if (dot_n >= 280 && dot_n <= 304 && line_n == -1) begin
      v[14:11] = t_addr[14:11];
      v[9:5]   = t_addr[9:5];
    end
    // coarse X step every eighth dot
    if ((dot_n >= 328 || dot_n <= 256) && dot_n != 0 && (dot_n % 8) == 0) begin
      if (v[4:0] == COARSE_MAX) begin
        v[4:0] = 5'd0;
        v[10]  = ~v[10];
      end else begin
        v = v + 15'd1;
      end
    end
    v_addr = v;
  endfunction

  // Work one beat through the local state and give its result
  function automatic reply_t advance_unit(beat_t b);
    reply_t r;
    r = '0;
    if (b.op == OP_TICK) begin
      if (line_n == -1 && dot_n == 1) flags = 3'd0;
      if (b.ovf) flags[0] = 1'b1;
      if (b.zhit) flags[1] = 1'b1;
      scroll_step();
      if (line_n == 241 && dot_n == 1) begin
        flags[2] = 1'b1;
        r.nmi = ctrl_r[7];
      end
      if (line_n < 240 && dot_n >= 257 && dot_n <= 320) oam_ptr = 8'd0;
      dot_n++;
      if (dot_n >= 341) begin
        dot_n = 0;
        line_n++;
        if (line_n >= 261) begin
          line_n = -1;
          r.frame_done = 1'b1;
        end
      end
      // odd-frame dot skip
      if (line_n == 0 && dot_n == 0) begin
        if (odd_n) dot_n = 1;
        odd_n = ~odd_n;
      end
    end else if (b.op == OP_WRITE) begin
      case (b.reg_sel)
        REG_CTRL: begin
          ctrl_r = b.wdata;
          t_addr[11:10] = b.wdata[1:0];
        end
        REG_MASK: mask_r = b.wdata;
        REG_OAM_ADDR: oam_ptr = b.wdata;
        REG_OAM_DATA: begin
          oam_mem[oam_ptr] = b.wdata;
          oam_ptr = oam_ptr + 8'd1;
        end
        REG_SCROLL: begin
          if (w_first) begin
            t_addr[4:0] = b.wdata[7:3];
            fx = b.wdata[2:0];
          end else begin
            t_addr[9:5]   = b.wdata[7:3];
            t_addr[14:12] = b.wdata[2:0];
          end
          w_first = ~w_first;
        end
        REG_ADDR: begin
          if (w_first) begin
            t_addr[14]   = 1'b0;
            t_addr[13:8] = b.wdata[5:0];
          end else begin
            t_addr[7:0] = b.wdata;
            v_addr = t_addr;
          end
          w_first = ~w_first;
        end
        REG_DATA: begin
          r.mem_addr = v_addr[13:0];
          r.mem_write = 1'b1;
          r.mem_write_data = b.wdata;
          v_addr = v_addr + (ctrl_r[2] ? 15'd32 : 15'd1);
        end
        default: ;
      endcase
    end else if (b.op == OP_READ) begin
      case (b.reg_sel)
        REG_STATUS: begin
          r.read_data = {flags, rbuf[4:0]};
          flags[2] = 1'b0;
          w_first = 1'b1;
        end
        REG_OAM_DATA: r.read_data = oam_mem[oam_ptr];
        REG_DATA: begin
          r.mem_addr = v_addr[13:0];
          r.mem_read = 1'b1;
          r.read_data = rbuf;
          rbuf = b.mdata;
          // palette page bypasses the buffer
          if (v_addr[13:8] == PALETTE_PAGE) r.read_data = rbuf;
          v_addr = v_addr + (ctrl_r[2] ? 15'd32 : 15'd1);
        end
        default: ;
      endcase
    end
    r.video_address = v_addr;
    r.fine_x = fx;
    r.dot = dot_n[8:0];
    r.line = line_n[9:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      bad_fields++;
      if (bad_fields <= 10) $display("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // Result beats checked first, then the accepted input beat predicted
  always @(posedge clk) begin : scoreboard
    reply_t want;
    reply_t got;
    beat_t  seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.read_data      = read_data;
        got.mem_addr       = mem_addr;
        got.mem_write      = mem_write;
        got.mem_write_data = mem_write_data;
        got.mem_read       = mem_read;
        got.video_address  = video_address;
        got.fine_x         = fine_x_scroll;
        got.nmi            = nmi_pulse;
        got.frame_done     = frame_done;
        got.dot            = dot;
        got.line           = line;
        if (unit_replies.size() == 0) begin
          bad_fields++;
          if (bad_fields <= 10) $display("result beat with nothing outstanding");
        end else begin
          want = unit_replies.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("mem_addr", want.mem_addr, got.mem_addr);
          check_field("mem_write", want.mem_write, got.mem_write);
          check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
          check_field("mem_read", want.mem_read, got.mem_read);
          check_field("video_address", want.video_address, got.video_address);
          check_field("fine_x_scroll", want.fine_x, got.fine_x);
          check_field("nmi_pulse", want.nmi, got.nmi);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("dot", want.dot, got.dot);
          check_field("line", want.line, got.line);
        end
      end
      if (in_valid && in_ready) begin
        seen = '{op, reg_idx_t'(reg_index), write_data, mem_read_data,
                 overflow_event, zero_hit_event, pin_on, pin_rd};
        want = advance_unit(seen);
        if (pin_on) want.read_data = pin_rd;
        unit_replies.push_back(want);
      end
    end
  end

  // Result side: random back-pressure plus one long hold on request
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done = holds_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Offer one beat and hold it until taken
  task automatic send_beat(input beat_t b);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= b.op;
    reg_index      <= b.reg_sel;
    write_data     <= b.wdata;
    mem_read_data  <= b.mdata;
    overflow_event <= b.ovf;
    zero_hit_event <= b.zhit;
    pin_on         <= b.pinned;
    pin_rd         <= b.pin_rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.op == OP_TICK) ticks_sent++;
    else accesses_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (unit_replies.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic beat_t beat_of(logic [1:0] o, reg_idx_t rg, logic [7:0] d);
    beat_t b;
    b.op = o;
    b.reg_sel = rg;
    b.wdata = d;
    b.mdata = 8'($urandom_range(0, 255));
    b.ovf = ($urandom_range(0, 99) < 4);
    b.zhit = ($urandom_range(0, 99) < 4);
    b.pinned = 1'b0;
    b.pin_rd = 8'h00;
    return b;
  endfunction

  task automatic send_ticks(int n);
    repeat (n) send_beat(beat_of(OP_TICK, reg_idx_t'($urandom_range(0, 7)),
                                 8'($urandom_range(0, 255))));
  endtask

  // One CPU access sequence: mostly well-formed, some broken or noise
  task automatic send_sequence();
    int         kind;
    logic [7:0] d;
    beat_t      b;
    kind = $urandom_range(0, 9);
    case (kind)
      0: send_beat(beat_of(OP_WRITE, REG_CTRL, 8'($urandom_range(0, 255))));
      1: begin
        // rendering left on most of the time
        d = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0) d[3] = 1'b1;
        send_beat(beat_of(OP_WRITE, REG_MASK, d));
      end
      2: begin
        send_beat(beat_of(OP_READ, REG_STATUS, 8'($urandom_range(0, 255))));
        send_beat(beat_of(OP_WRITE, REG_SCROLL, 8'($urandom_range(0, 255))));
        send_beat(beat_of(OP_WRITE, REG_SCROLL, 8'($urandom_range(0, 255))));
      end
      3, 4: begin
        d = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) d[5:0] = PALETTE_PAGE;
        send_beat(beat_of(OP_READ, REG_STATUS, 8'($urandom_range(0, 255))));
        send_beat(beat_of(OP_WRITE, REG_ADDR, d));
        send_beat(beat_of(OP_WRITE, REG_ADDR, 8'($urandom_range(0, 255))));
        repeat ($urandom_range(1, 4))
          send_beat(beat_of($urandom_range(0, 1) ? OP_READ : OP_WRITE, REG_DATA,
                            8'($urandom_range(0, 255))));
      end
      5: begin
        send_beat(beat_of(OP_WRITE, REG_OAM_ADDR, 8'($urandom_range(0, 255))));
        repeat ($urandom_range(1, 3))
          send_beat(beat_of($urandom_range(0, 1) ? OP_READ : OP_WRITE, REG_OAM_DATA,
                            8'($urandom_range(0, 255))));
      end
      6: send_beat(beat_of(OP_READ, REG_STATUS, 8'($urandom_range(0, 255))));
      7: begin
        // noise: any op, any register, event bits freely
        b = beat_of(2'($urandom_range(0, 3)), reg_idx_t'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)));
        b.ovf = 1'($urandom_range(0, 1));
        b.zhit = 1'($urandom_range(0, 1));
        send_beat(b);
      end
      8: send_beat(beat_of(OP_WRITE, $urandom_range(0, 1) ? REG_SCROLL : REG_ADDR,
                           8'($urandom_range(0, 255))));
      default: send_beat(beat_of($urandom_range(0, 1) ? OP_READ : OP_WRITE, REG_DATA,
                                 8'($urandom_range(0, 255))));
    endcase
  endtask

  initial begin : stimulus
    int seg;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    op             <= OP_TICK;
    reg_index      <= REG_CTRL;
    write_data     <= 8'h00;
    mem_read_data  <= 8'h00;
    overflow_event <= 1'b0;
    zero_hit_event <= 1'b0;
    pin_on         <= 1'b0;
    pin_rd         <= 8'h00;
    gaps_on        <= 1'b1;
    holds_asked    <= 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIR_ROWS); i++) send_beat(DIR_ROWS[i]);

    // fill the attribute store so any later read hits a written entry
    send_beat(beat_of(OP_WRITE, REG_OAM_ADDR, 8'h00));
    repeat (OAM_BYTES) send_beat(beat_of(OP_WRITE, REG_OAM_DATA, 8'($urandom_range(0, 255))));

    // bursts of accesses between short tick runs
    seg = 0;
    while (ticks_sent + accesses_sent < ITEM_TARGET || seg < 14) begin
      gaps_on <= !(seg >= 9 && seg <= 13);
      if (seg == 3) holds_asked <= holds_asked + 1;
      if (seg == 6) wait_drained();
      repeat ($urandom_range(1, 3)) begin
        send_sequence();
        send_ticks($urandom_range(0, 3));
      end
      send_ticks($urandom_range(2, 10));
      seg++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (bad_fields == 0 && unit_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
